/* src/snb_pkg.sv */
// Shared constants, types and character helpers for the 8.3 short name builder.
package snb_pkg;

  localparam int unsigned NameLen  = 8;
  localparam int unsigned ExtLen   = 3;
  localparam int unsigned CharW    = 8;
  localparam int unsigned NameW    = NameLen * CharW;
  localparam int unsigned ExtW     = ExtLen * CharW;
  localparam int unsigned OutDataW = ((NameW + ExtW + 7) / 8) * 8;

  localparam logic [CharW-1:0] SpaceChar = 8'h20;
  localparam logic [CharW-1:0] DotChar   = 8'h2E;

  localparam logic [NameW-1:0] NameSpaces = {NameLen{SpaceChar}};
  localparam logic [ExtW-1:0]  ExtSpaces  = {ExtLen{SpaceChar}};
  localparam logic [NameW-1:0] OneDotName = {DotChar, {(NameLen - 1){SpaceChar}}};
  localparam logic [NameW-1:0] TwoDotName = {DotChar, DotChar, {(NameLen - 2){SpaceChar}}};

  typedef logic [CharW-1:0] char_t;
  typedef logic [3:0]       wpos_t;
  typedef logic [1:0]       seen_t;

  function automatic logic is_alnum(input char_t c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic char_t to_upper(input char_t c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      to_upper = c - 8'h20;
    end else begin
      to_upper = c;
    end
  endfunction

endpackage

/* src/short_name_builder.sv */
// Top level of the 8.3 short name builder: beat register, name state, result register.
// A terminating beat passes the input beat register, then the result register, before its result shows.
// Throughput: one character beat per clock; the input register only stalls when a
//   finished result still sits unread in the output register and another end beat waits.
// Reset: rst_ni clears the valid bits of both beat registers and returns the name state to
//   all spaces, name part, position zero, no characters seen.
module short_name_builder
  import snb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CharW-1:0]    s_axis_tdata_i,   // [7:0] ch
  input  logic                s_axis_tlast_i,   // end_of_name
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [63:0] name_part, [87:64] ext_part
);

  // Input beat register
  logic  in_valid_q;
  char_t in_ch_q;
  logic  in_end_q;

  // Name state
  logic             in_ext_q, in_ext_d;
  wpos_t            wpos_q, wpos_d;
  logic [NameW-1:0] name_q, name_d;
  logic [ExtW-1:0]  ext_q, ext_d;
  seen_t            seen_q, seen_d;
  logic             only_dots_q, only_dots_d;

  // Result register
  logic             out_valid_q;
  logic [NameW-1:0] out_name_q, out_name_d;
  logic [ExtW-1:0]  out_ext_q, out_ext_d;

  logic  advance;
  logic  keep;
  char_t up_ch;

  // The held beat moves on unless it is an end beat and the result slot is full and not being read.
  assign advance = in_valid_q && (!in_end_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign keep  = is_alnum(in_ch_q);
  assign up_ch = to_upper(in_ch_q);

  always_comb begin
    in_ext_d    = in_ext_q;
    wpos_d      = wpos_q;
    name_d      = name_q;
    ext_d       = ext_q;
    seen_d      = seen_q;
    only_dots_d = only_dots_q;
    out_name_d  = out_name_q;
    out_ext_d   = out_ext_q;

    if (in_end_q) begin
      // Emit and fall back to the reset state; lone "." and ".." are special names.
      out_name_d = name_q;
      out_ext_d  = ext_q;
      if (only_dots_q && seen_q == 2'd1) begin
        out_name_d = OneDotName;
        out_ext_d  = ExtSpaces;
      end else if (only_dots_q && seen_q == 2'd2) begin
        out_name_d = TwoDotName;
        out_ext_d  = ExtSpaces;
      end
      in_ext_d    = 1'b0;
      wpos_d      = '0;
      name_d      = NameSpaces;
      ext_d       = ExtSpaces;
      seen_d      = '0;
      only_dots_d = 1'b1;
    end else begin
      if (seen_q != 2'd3) begin
        seen_d = seen_q + 2'd1;
      end
      if (in_ch_q != DotChar) begin
        only_dots_d = 1'b0;
      end

      if (!in_ext_q) begin
        if (in_ch_q == DotChar) begin
          in_ext_d = 1'b1;
          wpos_d   = '0;
        end else if (wpos_q < wpos_t'(NameLen) && keep) begin
          // first character lands in the top byte
          for (int unsigned i = 0; i < NameLen; i++) begin
            if (wpos_q == wpos_t'(i)) begin
              name_d[(NameLen - 1 - i) * CharW +: CharW] = up_ch;
            end
          end
          wpos_d = wpos_q + 4'd1;
        end
      end else if (wpos_q < wpos_t'(ExtLen) && keep) begin
        for (int unsigned i = 0; i < ExtLen; i++) begin
          if (wpos_q == wpos_t'(i)) begin
            ext_d[(ExtLen - 1 - i) * CharW +: CharW] = up_ch;
          end
        end
        wpos_d = wpos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_ext_q    <= 1'b0;
      wpos_q      <= '0;
      name_q      <= NameSpaces;
      ext_q       <= ExtSpaces;
      seen_q      <= '0;
      only_dots_q <= 1'b1;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        in_ext_q    <= in_ext_d;
        wpos_q      <= wpos_d;
        name_q      <= name_d;
        ext_q       <= ext_d;
        seen_q      <= seen_d;
        only_dots_q <= only_dots_d;
      end
      if (advance && in_end_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_ch_q  <= s_axis_tdata_i;
      in_end_q <= s_axis_tlast_i;
    end
    if (advance && in_end_q) begin
      out_name_q <= out_name_d;
      out_ext_q  <= out_ext_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_ext_q, out_name_q});

endmodule

/* sim/testbench.sv */
// Stream testbench for the 8.3 short name builder: predicts each converted name and checks it.
`timescale 1ns / 100ps

module testbench;
  import snb_pkg::*;

  // One converted name as it leaves the block: [63:0] name, [87:64] extension.
  typedef struct packed {
    logic [ExtW-1:0]  ext;
    logic [NameW-1:0] name;
  } short_name_t;

  // One row of the directed table; want is only used when typed is set.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             typed;
    short_name_t      want;
  } stim_row_t;

  localparam short_name_t AllSpaces = '{ext: 24'h202020, name: 64'h2020202020202020};
  localparam short_name_t OneDot    = '{ext: 24'h202020, name: 64'h2E20202020202020};
  localparam short_name_t TwoDots   = '{ext: 24'h202020, name: 64'h2E2E202020202020};
  localparam short_name_t NoCheck   = '0;

  localparam int DirRows = 28;
  localparam int MaxShown = 10;

  // Empty name, one dot, two dots, three dots, then a name that overflows both
  // parts, carries NUL and 0xFF, letter/digit extremes and a second dot.
  localparam stim_row_t DirTable [DirRows] = '{
    '{8'h5A, 1'b1, 1'b1, AllSpaces},
    '{8'h2E, 1'b0, 1'b0, NoCheck},
    '{8'hFF, 1'b1, 1'b1, OneDot},
    '{8'h2E, 1'b0, 1'b0, NoCheck},
    '{8'h2E, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b1, 1'b1, TwoDots},
    '{8'h2E, 1'b0, 1'b0, NoCheck},
    '{8'h2E, 1'b0, 1'b0, NoCheck},
    '{8'h2E, 1'b0, 1'b0, NoCheck},
    '{8'h80, 1'b1, 1'b1, AllSpaces},
    '{"a",   1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{8'hFF, 1'b0, 1'b0, NoCheck},
    '{"z",   1'b0, 1'b0, NoCheck},
    '{"Z",   1'b0, 1'b0, NoCheck},
    '{"0",   1'b0, 1'b0, NoCheck},
    '{"9",   1'b0, 1'b0, NoCheck},
    '{"Q",   1'b0, 1'b0, NoCheck},
    '{"R",   1'b0, 1'b0, NoCheck},
    '{"T",   1'b0, 1'b0, NoCheck},
    '{"U",   1'b0, 1'b0, NoCheck},
    '{".",   1'b0, 1'b0, NoCheck},
    '{"e",   1'b0, 1'b0, NoCheck},
    '{".",   1'b0, 1'b0, NoCheck},
    '{"x",   1'b0, 1'b0, NoCheck},
    '{"y",   1'b0, 1'b0, NoCheck},
    '{"w",   1'b0, 1'b0, NoCheck},
    '{8'h41, 1'b1, 1'b0, NoCheck}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [CharW-1:0]    s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  short_name_builder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted name state.
  logic             ext_open;
  logic [3:0]       put_pos;
  logic [NameW-1:0] name_acc;
  logic [ExtW-1:0]  ext_acc;
  logic [1:0]       seen_cnt;
  logic             dots_only;

  short_name_t pending_names[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;

  task automatic clear_name_state();
    ext_open  = 1'b0;
    put_pos   = '0;
    name_acc  = 64'h2020202020202020;
    ext_acc   = 24'h202020;
    seen_cnt  = '0;
    dots_only = 1'b1;
  endtask

  // Folds one beat into the predicted state; done is set on the end beat.
  task automatic convert_beat(input logic [CharW-1:0] ch, input logic last,
                              output logic done, output short_name_t res);
    logic             keep;
    logic [CharW-1:0] up;
    keep = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h61 && ch <= 8'h7A);
    up   = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
    done = last;
    res  = '{ext: ext_acc, name: name_acc};
    if (last) begin
      if (dots_only && seen_cnt == 2'd1) begin
        res = '{ext: 24'h202020, name: 64'h2E20202020202020};
      end else if (dots_only && seen_cnt == 2'd2) begin
        res = '{ext: 24'h202020, name: 64'h2E2E202020202020};
      end
      clear_name_state();
    end else begin
      if (seen_cnt != 2'd3) seen_cnt = seen_cnt + 2'd1;
      if (ch != DotChar) dots_only = 1'b0;
      if (!ext_open) begin
        if (ch == DotChar) begin
          ext_open = 1'b1;
          put_pos  = '0;
        end else if (put_pos < NameLen && keep) begin
          name_acc[8 * (NameLen - 1 - put_pos) +: 8] = up;
          put_pos = put_pos + 4'd1;
        end
      end else if (put_pos < ExtLen && keep) begin
        ext_acc[8 * (ExtLen - 1 - put_pos) +: 8] = up;
        put_pos = put_pos + 4'd1;
      end
    end
  endtask

  // Offers one beat, waits for the handshake, then records the expected name.
  task automatic send_beat(input logic [CharW-1:0] ch, input logic last,
                           input logic typed, input short_name_t want);
    logic        done;
    short_name_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    beats_sent++;
    convert_beat(ch, last, done, res);
    if (done) pending_names.push_back(typed ? want : res);
  endtask

  function automatic logic [CharW-1:0] pick_char();
    logic [CharW-1:0] ch;
    case ($urandom_range(9))
      0, 1, 2: ch = 8'h41 + 8'($urandom_range(25));
      3, 4, 5: ch = 8'h61 + 8'($urandom_range(25));
      6, 7:    ch = 8'h30 + 8'($urandom_range(9));
      8:       ch = 8'($urandom_range(255));
      default: begin
        // bytes just outside the letter and digit ranges, plus the dot
        case ($urandom_range(6))
          0: ch = 8'h2F;
          1: ch = 8'h3A;
          2: ch = 8'h40;
          3: ch = 8'h5B;
          4: ch = 8'h60;
          5: ch = 8'h7B;
          default: ch = DotChar;
        endcase
      end
    endcase
    return ch;
  endfunction

  // One name of random shape: mostly base plus extension, some dot-only names.
  task automatic send_random_name();
    int n_name;
    int n_ext;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 4)) send_beat(DotChar, 1'b0, 1'b0, NoCheck);
    end else begin
      n_name = ($urandom_range(3) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 8);
      repeat (n_name) send_beat(pick_char(), 1'b0, 1'b0, NoCheck);
      if ($urandom_range(3) != 0) begin
        send_beat(DotChar, 1'b0, 1'b0, NoCheck);
        n_ext = $urandom_range(0, 5);
        repeat (n_ext) send_beat(pick_char(), 1'b0, 1'b0, NoCheck);
      end
    end
    send_beat(8'($urandom_range(255)), 1'b1, 1'b0, NoCheck);
  endtask

  // Holds the sender until every expected name has come back, with a cap.
  task automatic drain_names();
    int waited;
    waited = 0;
    while (pending_names.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int beat_goal);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (beats_sent < beat_goal) send_random_name();
  endtask

  task automatic note_mismatch(input string what, input logic [NameW-1:0] want,
                               input logic [NameW-1:0] got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Checks each output beat against the oldest expected name.
  always @(posedge clk_i) begin : check_output
    short_name_t got;
    short_name_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_names.size() == 0) begin
        note_mismatch("unexpected beat", '0, {got.ext, got.name[NameW-ExtW-1:0]});
      end else begin
        want = pending_names.pop_front();
        if (got.name !== want.name) note_mismatch("name part", want.name, got.name);
        if (got.ext !== want.ext) note_mismatch("extension", NameW'(want.ext), NameW'(got.ext));
      end
    end
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    clear_name_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_beat(DirTable[i].ch, DirTable[i].last, DirTable[i].typed, DirTable[i].want);
    end

    run_phase(9, 81, 620);
    s_tvalid <= 1'b0;
    drain_names();
    run_phase(81, 9, 1200);
    s_tvalid <= 1'b0;
    drain_names();
    // long receiver hold-off while names keep coming: fills the block until it stalls
    hold_left = 400;
    run_phase(0, 0, 1780);
    s_tvalid <= 1'b0;

    drain_names();
    repeat (8) @(posedge clk_i);
    mismatches += pending_names.size();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
